>>> rtl/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared types and constants of the tandem Goertzel tone power core.
// ----------------------------------------------------------------------------
package gtp_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int WIN_W      = 16;
  localparam int COUNT_W    = 17;
  localparam int RATIO_W    = 16;
  localparam int MUL_DIGIT  = 16;
  localparam int DIV_CNT_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_TONE_COEFF    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;

  localparam logic [COUNT_W-1:0]   COUNT_MAX    = 17'h1FFFF;
  localparam logic [RATIO_W-1:0]   RATIO_MAX    = 16'hFFFF;
  localparam logic [WIN_W-1:0]     WINDOW_RESET = 16'd512;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST     = 4'd15;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LOAD = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_NEG  = 8'b0000_1000,
    S_WB   = 8'b0001_0000,
    S_UPD  = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  typedef enum logic [2:0] {
    OP_SQ  = 3'd0,
    OP_CL0 = 3'd1,
    OP_CL1 = 3'd2,
    OP_PL  = 3'd3,
    OP_PP  = 3'd4,
    OP_LL  = 3'd5,
    OP_PPR = 3'd6,
    OP_EC  = 3'd7
  } op_e;

endpackage

>>> rtl/gtp_if.sv
// ----------------------------------------------------------------------------
// gtp channel interfaces
// Sample, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gtp_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface gtp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] power_ratio;
  logic        active_half;
  modport source (output valid, output power_ratio, output active_half, input ready);
  modport sink   (input valid, input power_ratio, input active_half, output ready);
endinterface

interface gtp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/tandem_goertzel_tone_power_core.sv
// ----------------------------------------------------------------------------
// tandem_goertzel_tone_power_core
// Two ping-pong Goertzel resonators on one coefficient, normalised tone power.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                      | request accepted when
//  cfg_sink  | in  | index, data                  | valid & ready (ready always)
//  in_sink   | in  | sample                       | valid & ready (ready in idle)
//  out_src   | out | power_ratio, active_half     | valid & ready
//
//  Eight products run through one shared multiplier at 16 bits a cycle,
//  then a 16-step restoring divider, which runs only when the ratio is
//  neither zero nor saturated. The result waits in its register until
//  taken; no new sample meanwhile.
//  Reset clears all resonator state and loads the register defaults.
// ----------------------------------------------------------------------------
module tandem_goertzel_tone_power_core #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 48,
  parameter int COEFF_FRAC   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gtp_cfg_if.sink   cfg_sink,
  gtp_in_if.sink    in_sink,
  gtp_out_if.source out_src
);
  import gtp_pkg::*;

  localparam int COEFF_W = COEFF_FRAC + 3;
  localparam int MAG_W   = ACC_WIDTH + 2;
  localparam int SW      = MAG_W + 1;
  localparam int NCH     = (MAG_W + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int BW      = NCH * MUL_DIGIT;
  localparam int AW      = 2 * MAG_W;
  localparam int PRW     = AW + 1;
  localparam int TW      = PRW + 2;
  localparam int PWW     = AW + 3;
  localparam int DENW    = AW + 2 * COEFF_FRAC;
  localparam int CW      = DENW + 1;
  localparam int RW      = CW + 1;
  localparam int SQ_W    = 2 * SAMPLE_WIDTH;
  localparam int EW      = ACC_WIDTH + SQ_W + 1;
  localparam int CNT_W   = $clog2(NCH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NCH - 1);

  state_e state_q;
  op_e    op_q;

  logic signed [COEFF_W-1:0]      coeff_q;
  logic [WIN_W-1:0]               win_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [ACC_WIDTH-1:0]    last_q [2];
  logic signed [ACC_WIDTH-1:0]    prev_q [2];
  logic [ACC_WIDTH-1:0]           energy_q [2];
  logic [COUNT_W-1:0]             count_q [2];
  logic [WIN_W-1:0]               phase_q;
  logic                           act_q;

  logic [MAG_W-1:0]      a_q;
  logic [BW-1:0]         b_q;
  logic                  neg_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [AW-1:0]         acc_q;
  logic signed [PRW-1:0] prod_q;
  logic [SQ_W-1:0]       sq_q;
  logic signed [SW-1:0]  p_q;
  logic signed [PWW-1:0] pw_q;
  logic [CW-1:0]         den_q;
  logic [RW-1:0]         rem_q;
  logic [RATIO_W-1:0]    quo_q;
  logic [DIV_CNT_W-1:0]  dcnt_q;
  logic [RATIO_W-1:0]    ratio_q;
  logic                  half_q;

  // operand select
  logic                  hsel;
  logic                  rsel;
  logic signed [SW-1:0]  opa;
  logic signed [SW-1:0]  opb;
  logic [MAG_W-1:0]      mag_a;
  logic [MAG_W-1:0]      mag_b;

  assign hsel = (op_q == OP_CL1);
  assign rsel = ((op_q == OP_CL0) || (op_q == OP_CL1)) ? hsel : act_q;

  always_comb begin
    unique case (op_q)
      OP_SQ: begin
        opa = SW'(x_q);
        opb = SW'(x_q);
      end
      OP_CL0, OP_CL1, OP_PL: begin
        opa = SW'(coeff_q);
        opb = SW'(last_q[rsel]);
      end
      OP_PP: begin
        opa = SW'(prev_q[rsel]);
        opb = SW'(prev_q[rsel]);
      end
      OP_LL: begin
        opa = SW'(last_q[rsel]);
        opb = SW'(last_q[rsel]);
      end
      OP_PPR: begin
        opa = p_q;
        opb = SW'(prev_q[rsel]);
      end
      OP_EC: begin
        opa = $signed(SW'(energy_q[rsel]));
        opb = $signed(SW'(count_q[rsel]));
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    mag_a = MAG_W'(opa[SW-1] ? -opa : opa);
    mag_b = MAG_W'(opb[SW-1] ? -opb : opb);
  end

  // multiplier digit step
  logic [AW-1:0] acc_d;
  assign acc_d = (acc_q << MUL_DIGIT)
               + (AW'(a_q) * AW'(b_q[BW-1 -: MUL_DIGIT]));

  // resonator write back
  logic signed [PRW-1:0]       cl_sh;
  logic signed [TW-1:0]        t_sum;
  logic                        t_fits;
  logic signed [ACC_WIDTH-1:0] t_sat;

  assign cl_sh  = prod_q >>> COEFF_FRAC;
  assign t_sum  = (TW'(x_q) <<< COEFF_FRAC) + TW'(cl_sh) - TW'(prev_q[hsel]);
  assign t_fits = (t_sum[TW-1:ACC_WIDTH-1] == '0) || (t_sum[TW-1:ACC_WIDTH-1] == '1);
  assign t_sat  = t_fits ? t_sum[ACC_WIDTH-1:0]
                : (t_sum[TW-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                               : {1'b0, {(ACC_WIDTH-1){1'b1}}});

  // phase and energy update
  logic [WIN_W-1:0]   win_e;
  logic [WIN_W:0]     ph_inc;
  logic               wrap;
  logic               act_d;
  logic               idle_h;
  logic               clr;
  logic [EW-1:0]      e_sum [2];
  logic [ACC_WIDTH-1:0] e_d [2];

  assign win_e  = (win_q == '0) ? WIN_W'(1) : win_q;
  assign ph_inc = (WIN_W+1)'(phase_q) + (WIN_W+1)'(1);
  assign wrap   = (ph_inc >= (WIN_W+1)'(win_e));
  assign act_d  = act_q ^ wrap;
  assign idle_h = ~act_d;
  assign clr    = (count_q[idle_h] >= COUNT_W'(win_e));

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      e_sum[h] = ((clr && (h[0] == idle_h)) ? '0 : EW'(energy_q[h])) + EW'(sq_q);
      e_d[h]   = (e_sum[h][EW-1:ACC_WIDTH] != '0) ? '1 : e_sum[h][ACC_WIDTH-1:0];
    end
  end

  // divider
  logic [CW-1:0]  den_d;
  logic [CW-1:0]  pw_u;
  logic [RW-1:0]  rem_sh;
  logic           rem_ge;

  assign den_d  = CW'({prod_q[AW-1:0], {(2*COEFF_FRAC){1'b0}}});
  assign pw_u   = CW'(pw_q);
  assign rem_sh = rem_q << 1;
  assign rem_ge = (rem_sh >= RW'(den_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_SQ;
      coeff_q <= '0;
      win_q   <= WINDOW_RESET;
      phase_q <= '0;
      act_q   <= 1'b0;
      cnt_q   <= '0;
      dcnt_q  <= '0;
      for (int h = 0; h < 2; h++) begin
        last_q[h]   <= '0;
        prev_q[h]   <= '0;
        energy_q[h] <= '0;
        count_q[h]  <= '0;
      end
    end else begin
      if (cfg_sink.valid) begin
        unique case (cfg_sink.index)
          CFG_TONE_COEFF:    coeff_q <= $signed(cfg_sink.data[COEFF_W-1:0]);
          CFG_WINDOW_LENGTH: win_q   <= cfg_sink.data[WIN_W-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_sink.valid) begin
            x_q     <= in_sink.sample;
            op_q    <= OP_SQ;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          a_q     <= mag_a;
          b_q     <= BW'(mag_b);
          neg_q   <= opa[SW-1] ^ opb[SW-1];
          acc_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          acc_q <= acc_d;
          b_q   <= b_q << MUL_DIGIT;
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_LAST) begin
            state_q <= S_NEG;
          end
        end
        S_NEG: begin
          prod_q  <= neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
          state_q <= S_WB;
        end
        S_WB: begin
          state_q <= S_LOAD;
          op_q    <= op_e'(op_q + 3'd1);
          unique case (op_q)
            OP_SQ: sq_q <= prod_q[SQ_W-1:0];
            OP_CL0, OP_CL1: begin
              prev_q[hsel] <= last_q[hsel];
              last_q[hsel] <= t_sat;
              if (count_q[hsel] < COUNT_MAX) begin
                count_q[hsel] <= count_q[hsel] + COUNT_W'(1);
              end
              if (hsel) begin
                state_q <= S_UPD;
              end
            end
            OP_PL:  p_q  <= SW'(cl_sh);
            OP_PP:  pw_q <= PWW'(prod_q);
            OP_LL:  pw_q <= pw_q + PWW'(prod_q);
            OP_PPR: pw_q <= pw_q - PWW'(prod_q);
            OP_EC: begin
              if (pw_q[PWW-1] || (den_d == '0)) begin
                ratio_q <= '0;
                state_q <= S_OUT;
              end else if (pw_u >= den_d) begin
                ratio_q <= RATIO_MAX;
                state_q <= S_OUT;
              end else begin
                den_q   <= den_d;
                rem_q   <= RW'(pw_u);
                quo_q   <= '0;
                dcnt_q  <= '0;
                state_q <= S_DIV;
              end
            end
            default: ;
          endcase
          half_q <= act_q;
        end
        S_UPD: begin
          phase_q <= wrap ? '0 : ph_inc[WIN_W-1:0];
          act_q   <= act_d;
          if (clr) begin
            last_q[idle_h]  <= '0;
            prev_q[idle_h]  <= '0;
            count_q[idle_h] <= '0;
          end
          energy_q[0] <= e_d[0];
          energy_q[1] <= e_d[1];
          state_q     <= S_LOAD;
        end
        S_DIV: begin
          rem_q  <= rem_ge ? (rem_sh - RW'(den_q)) : rem_sh;
          quo_q  <= {quo_q[RATIO_W-2:0], rem_ge};
          dcnt_q <= dcnt_q + DIV_CNT_W'(1);
          if (dcnt_q == DIV_LAST) begin
            ratio_q <= {quo_q[RATIO_W-2:0], rem_ge};
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_src.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_sink.ready      = 1'b1;
  assign in_sink.ready       = (state_q == S_IDLE);
  assign out_src.valid       = (state_q == S_OUT);
  assign out_src.power_ratio = ratio_q;
  assign out_src.active_half = half_q;

endmodule

>>> rtl/gtp_checker.sv
// ----------------------------------------------------------------------------
// gtp_checker
// Port-level checks of the tandem Goertzel tone power core.
// ----------------------------------------------------------------------------
module gtp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_ratio_i,
  input logic        out_half_i
);

  // one sample in flight at a time
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while a result is pending");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !out_valid_i)
    else $error("result raised in the cycle after a request");

  a_ready_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i) |=> in_ready_i)
    else $error("input not ready after result taken");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_ratio_i) && $stable(out_half_i)))
    else $error("stalled result changed");

endmodule

bind tandem_goertzel_tone_power_core gtp_checker u_gtp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_sink.valid),
  .in_ready_i  (in_sink.ready),
  .out_valid_i (out_src.valid),
  .out_ready_i (out_src.ready),
  .out_ratio_i (out_src.power_ratio),
  .out_half_i  (out_src.active_half)
);
